>>> rtl/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants for the LRU frame replacer.
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int FRAMES_DEF = 64;

  localparam int ID_W  = 6;
  localparam int REQ_W = 2;
  localparam int CAP_W = 7;
  localparam int OCNT_W = 7;

  localparam logic [CAP_W-1:0] CAPACITY_RST = 7'd64;

  localparam logic [REQ_W-1:0] REQ_VICTIM = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIN    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UNPIN  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [ID_W-1:0]  frame_no;
  } in_t;

  typedef struct packed {
    logic              victim_found;
    logic [ID_W-1:0]   victim_frame;
    logic [OCNT_W-1:0] tracked_count;
  } out_t;

  // one-cycle list operation, at most one bit set
  typedef struct packed {
    logic pop;
    logic pin;
    logic push;
  } chain_ctl_t;

endpackage

>>> rtl/lfr_cell.sv
// ----------------------------------------------------------------------------
// lfr_cell
// One list position: frame id and occupancy, compare against the request id.
// ----------------------------------------------------------------------------
module lfr_cell
  import lfr_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  chain_ctl_t      ctl,
  input  logic            shift,
  input  logic [ID_W-1:0] cmp_id,
  input  logic            prev_valid,
  input  logic [ID_W-1:0] next_id,
  input  logic            next_valid,
  output logic [ID_W-1:0] id_o,
  output logic            valid_o,
  output logic            match_o
);

  logic [ID_W-1:0] id_r;
  logic            valid_r;
  logic            take_next;
  logic            load_new;

  assign take_next = ctl.pop || (ctl.pin && shift);
  // first empty slot after the occupied run
  assign load_new  = ctl.push && !valid_r && prev_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_next) begin
      valid_r <= next_valid;
    end else if (load_new) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_next) begin
      id_r <= next_id;
    end else if (load_new) begin
      id_r <= cmp_id;
    end
  end

  assign id_o    = id_r;
  assign valid_o = valid_r;
  assign match_o = valid_r && (id_r == cmp_id);

endmodule

>>> rtl/lfr_cell_chain.sv
// ----------------------------------------------------------------------------
// lfr_cell_chain
// Row of list cells, head at position 0, with registered match and shift mask.
// ----------------------------------------------------------------------------
module lfr_cell_chain
  import lfr_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  chain_ctl_t      ctl,
  input  logic [ID_W-1:0] cmp_id,
  output logic [ID_W-1:0] head_id,
  output logic            head_valid,
  output logic            hit
);

  localparam int LVLS = $clog2(FRAMES);

  logic [ID_W-1:0]   id_w    [FRAMES];
  logic [FRAMES-1:0] valid_w;
  logic [FRAMES-1:0] match_w;
  logic [FRAMES-1:0] match_r;
  logic [FRAMES-1:0] pre     [LVLS+1];

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      logic            prev_v;
      logic [ID_W-1:0] nid;
      logic            nvalid;

      if (g == 0) begin : g_head
        assign prev_v = 1'b1;
      end else begin : g_body
        assign prev_v = valid_w[g-1];
      end

      if (g == FRAMES - 1) begin : g_tail
        assign nid    = '0;
        assign nvalid = 1'b0;
      end else begin : g_link
        assign nid    = id_w[g+1];
        assign nvalid = valid_w[g+1];
      end

      lfr_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .shift      (pre[LVLS][g]),
        .cmp_id     (cmp_id),
        .prev_valid (prev_v),
        .next_id    (nid),
        .next_valid (nvalid),
        .id_o       (id_w[g]),
        .valid_o    (valid_w[g]),
        .match_o    (match_w[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= '0;
    end else begin
      match_r <= match_w;
    end
  end

  // prefix OR: cells at or after the matching cell close the gap
  always_comb begin
    pre[0] = match_r;
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
  end

  assign head_id    = id_w[0];
  assign head_valid = valid_w[0];
  assign hit        = pre[LVLS][FRAMES-1];

endmodule

>>> rtl/lru_frame_replacer_core.sv
// ----------------------------------------------------------------------------
// lru_frame_replacer_core
// LRU replacer list of evictable frames built as a shifting row of cells.
//
//   port group   dir  handshake             payload
//   in_*         in   in_valid / in_ready   in_data   (in_t)
//   out_*        out  out_valid / out_ready out_data  (out_t)
//   cfg_*        in   cfg_we                cfg_wdata (capacity)
//
// A transaction passes through accept, match capture in the cells, and list
// update with result load; the registered cell match forms the capture step.
// A waiting result holds the update step until out_ready frees the output
// register; no new request is accepted meanwhile.
// Reset (rst_n, synchronous) empties the list and sets capacity to 64.
// ----------------------------------------------------------------------------
module lru_frame_replacer_core
  import lfr_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [LIM_W-1:0] FRAMES_L = LIM_W'(FRAMES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [REQ_W-1:0] req_r;
  logic [ID_W-1:0]  fid_r;
  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  chain_ctl_t       ctl;
  logic [ID_W-1:0]  head_id;
  logic             head_valid;
  logic             hit;
  logic             fire;
  logic             fid_ok;
  logic [LIM_W-1:0] cap_l, limit;
  logic             room;

  lfr_cell_chain #(
    .FRAMES (FRAMES)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .cmp_id     (fid_r),
    .head_id    (head_id),
    .head_valid (head_valid),
    .hit        (hit)
  );

  assign cap_l  = LIM_W'(capacity_r);
  assign limit  = (cap_l < FRAMES_L) ? cap_l : FRAMES_L;
  assign room   = LIM_W'(count_r) < limit;
  assign fid_ok = LIM_W'(fid_r) < FRAMES_L;
  assign fire   = (state_r == ST_APPLY) && (!out_valid_r || out_ready);

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    ctl       = '0;
    count_nxt = count_r;
    out_nxt   = out_r;
    if (fire) begin
      out_nxt = '0;
      case (req_r)
        REQ_VICTIM: begin
          if (count_r != '0) begin
            ctl.pop              = 1'b1;
            out_nxt.victim_found = 1'b1;
            out_nxt.victim_frame = head_id;
          end
        end
        REQ_PIN: ctl.pin = fid_ok && hit;
        REQ_UNPIN: ctl.push = fid_ok && !hit && room;
        default: ;
      endcase
      if (ctl.pop || ctl.pin) begin
        count_nxt = count_r - CNT_W'(1);
      end else if (ctl.push) begin
        count_nxt = count_r + CNT_W'(1);
      end
      out_nxt.tracked_count = OCNT_W'(count_nxt);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_APPLY;
      ST_APPLY: begin
        if (fire) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      capacity_r  <= CAPACITY_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data.req_type;
      fid_r <= in_data.frame_no;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= FRAMES)
    else $error("list count above frame count");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.pop, ctl.pin, ctl.push}))
    else $error("more than one list operation");

  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid == (count_r != '0))
    else $error("head cell occupancy disagrees with count");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_APPLY))
    else $error("result raised outside update step");

endmodule

>>> dv/lru_frame_replacer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_frame_replacer_core_test
// Self-checking bench for the LRU frame replacer core. A short directed table
// walks the empty, full and capacity corner cases. Random phases then mix
// fill and drain bursts under several capacities and idle patterns. Every
// reply is checked against a typed table entry, else a model of the eviction list.
// ----------------------------------------------------------------------------
module lru_frame_replacer_core_test;
  import lfr_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 88;
  localparam int DRAIN_CYCLES = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [CAP_W-1:0] PHASE_CAPS [PHASES] =
    '{7'd64, 7'd16, 7'd127, 7'd2, 7'd65, 7'd40, 7'd0, 7'd64};

  typedef struct {
    bit               cfg_row;
    logic [CAP_W-1:0] cap;
    in_t              req;
    bit               typed;
    out_t             reply;
  } plan_row_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  // typed expectation travelling with the directed transaction
  logic             dir_typed = 1'b0;
  out_t             dir_reply = '0;

  logic [ID_W-1:0]     lru_order[$];
  logic [FRAMES_DEF-1:0] resident_map;
  logic [CAP_W-1:0]    capacity_reg;
  out_t                predicted_replies[$];
  plan_row_t           directed_plan[$];
  int unsigned         mismatch_count = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;

  lru_frame_replacer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_t lru_apply(in_t req);
    out_t        reply;
    int unsigned limit;
    reply = '0;
    limit = (capacity_reg < FRAMES_DEF) ? capacity_reg : FRAMES_DEF;
    case (req.req_type)
      REQ_VICTIM: begin
        if (lru_order.size() != 0) begin
          reply.victim_found = 1'b1;
          reply.victim_frame = lru_order.pop_front();
          resident_map[reply.victim_frame] = 1'b0;
        end
      end
      REQ_PIN: begin
        if (resident_map[req.frame_no]) begin
          for (int i = 0; i < lru_order.size(); i++) begin
            if (lru_order[i] == req.frame_no) begin
              lru_order.delete(i);
              break;
            end
          end
          resident_map[req.frame_no] = 1'b0;
        end
      end
      REQ_UNPIN: begin
        if (!resident_map[req.frame_no] && lru_order.size() < limit) begin
          lru_order.push_back(req.frame_no);
          resident_map[req.frame_no] = 1'b1;
        end
      end
      default: ;
    endcase
    reply.tracked_count = OCNT_W'(lru_order.size());
    return reply;
  endfunction

  // fill bursts lean on unpins of absent frames, drain bursts on pins and victims
  function automatic in_t pick_request(bit filling);
    in_t         req;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    req.frame_no = ID_W'($urandom_range(0, FRAMES_DEF - 1));
    if (roll < (filling ? 70 : 20)) begin
      req.req_type = REQ_UNPIN;
      if (lru_order.size() < FRAMES_DEF && $urandom_range(0, 99) < 85) begin
        while (resident_map[req.frame_no])
          req.frame_no = ID_W'($urandom_range(0, FRAMES_DEF - 1));
      end
    end else if (roll < (filling ? 80 : 50)) begin
      req.req_type = REQ_PIN;
      if (lru_order.size() != 0 && $urandom_range(0, 9) < 8)
        req.frame_no = lru_order[$urandom_range(0, lru_order.size() - 1)];
    end else if (roll < 95) begin
      req.req_type = REQ_VICTIM;
    end else begin
      req.req_type = REQ_UNDEF;
    end
    return req;
  endfunction

  function automatic void plan_request(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id);
    plan_row_t row;
    row = '{cfg_row: 1'b0, cap: '0, req: '{kind, id}, typed: 1'b0, reply: '0};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_checked(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
                                       logic found, logic [ID_W-1:0] frame,
                                       logic [OCNT_W-1:0] count);
    plan_row_t row;
    row = '{cfg_row: 1'b0, cap: '0, req: '{kind, id}, typed: 1'b1,
            reply: '{found, frame, count}};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_capacity(logic [CAP_W-1:0] cap);
    plan_row_t row;
    row = '{cfg_row: 1'b1, cap: cap, req: '0, typed: 1'b0, reply: '0};
    directed_plan.push_back(row);
  endfunction

  // entered and left at a falling edge; valid stays up on exit
  task automatic send_request(in_t req, bit typed, out_t reply);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= req;
    dir_typed <= typed;
    dir_reply <= reply;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    while (predicted_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  always @(negedge clk)
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin : scoreboard
    out_t pred;
    out_t got;
    if (!rst_n) begin
      lru_order.delete();
      resident_map = '0;
      capacity_reg = CAPACITY_RST;
      quiet_cycles = 0;
    end else begin
      if (cfg_we)
        capacity_reg = cfg_wdata;
      if (in_valid && in_ready) begin
        pred = lru_apply(in_data);
        predicted_replies.push_back(dir_typed ? dir_reply : pred);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (predicted_replies.size() == 0) begin
          $error("unexpected transaction on out: %p", got);
          mismatch_count++;
        end else begin
          pred = predicted_replies.pop_front();
          if (got.victim_found !== pred.victim_found) begin
            $error("victim_found: expected %0d, got %0d", pred.victim_found,
                   got.victim_found);
            mismatch_count++;
          end
          if (got.victim_frame !== pred.victim_frame) begin
            $error("victim_frame: expected %0d, got %0d", pred.victim_frame,
                   got.victim_frame);
            mismatch_count++;
          end
          if (got.tracked_count !== pred.tracked_count) begin
            $error("tracked_count: expected %0d, got %0d", pred.tracked_count,
                   got.tracked_count);
            mismatch_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles", quiet_cycles);
          $display("lru_frame_replacer_core regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    bit               filling;
    int               burst_left;
    logic [CAP_W-1:0] cap;

    plan_checked(REQ_VICTIM, 6'd63, 1'b0, 6'd0, 7'd0);
    plan_checked(REQ_PIN,    6'd5,  1'b0, 6'd0, 7'd0);
    plan_checked(REQ_UNDEF,  6'd63, 1'b0, 6'd0, 7'd0);
    plan_checked(REQ_UNPIN,  6'd0,  1'b0, 6'd0, 7'd1);
    plan_request(REQ_UNPIN,  6'd63);
    plan_checked(REQ_UNPIN,  6'd0,  1'b0, 6'd0, 7'd2);
    plan_request(REQ_UNPIN,  6'd42);
    plan_checked(REQ_PIN,    6'd63, 1'b0, 6'd0, 7'd2);
    plan_checked(REQ_VICTIM, 6'd21, 1'b1, 6'd0, 7'd1);
    plan_checked(REQ_UNDEF,  6'd0,  1'b0, 6'd0, 7'd1);
    plan_checked(REQ_VICTIM, 6'd0,  1'b1, 6'd42, 7'd0);
    plan_checked(REQ_VICTIM, 6'd0,  1'b0, 6'd0, 7'd0);
    plan_checked(REQ_UNPIN,  6'd21, 1'b0, 6'd0, 7'd1);
    plan_request(REQ_UNPIN,  6'd42);
    plan_capacity(7'd1);
    plan_checked(REQ_UNPIN,  6'd7,  1'b0, 6'd0, 7'd2);
    plan_checked(REQ_PIN,    6'd21, 1'b0, 6'd0, 7'd1);
    plan_checked(REQ_UNPIN,  6'd7,  1'b0, 6'd0, 7'd1);
    plan_checked(REQ_VICTIM, 6'd0,  1'b1, 6'd42, 7'd0);
    plan_request(REQ_UNPIN,  6'd7);
    plan_capacity(7'd0);
    plan_checked(REQ_UNPIN,  6'd9,  1'b0, 6'd0, 7'd1);
    plan_checked(REQ_VICTIM, 6'd0,  1'b1, 6'd7, 7'd0);
    plan_checked(REQ_UNPIN,  6'd9,  1'b0, 6'd0, 7'd0);
    plan_capacity(7'd127);
    plan_checked(REQ_UNPIN,  6'd9,  1'b0, 6'd0, 7'd1);
    plan_request(REQ_PIN,    6'd42);
    plan_checked(REQ_VICTIM, 6'd0,  1'b1, 6'd9, 7'd0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].cfg_row)
        write_capacity(directed_plan[i].cap);
      else
        send_request(directed_plan[i].req, directed_plan[i].typed,
                     directed_plan[i].reply);
    end

    for (int p = 0; p < PHASES; p++) begin
      cap = (p == PHASES - 1) ? 7'($urandom_range(0, 127)) : PHASE_CAPS[p];
      write_capacity(cap);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      filling = 1'b1;
      burst_left = int'($urandom_range(20, 70));
      repeat (PHASE_ITEMS) begin
        if (burst_left == 0) begin
          filling = ~filling;
          burst_left = int'($urandom_range(8, 60));
        end
        send_request(pick_request(filling), 1'b0, '0);
        burst_left--;
      end
    end

    in_valid <= 1'b0;
    while (predicted_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("lru_frame_replacer_core regression: pass");
    else
      $display("lru_frame_replacer_core regression: fail");
    $finish;
  end

endmodule
